/* rtl/blr_pkg.sv */
// ----------------------------------------------------------------------------
// blr_pkg
// shared constants and codes for the bresenham line rasterizer
// ----------------------------------------------------------------------------
package blr_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 12;

	// item kinds carried on the input tuser
	typedef enum logic {
		MODE_START = 1'b0,
		MODE_STEP  = 1'b1
	} mode_t;

endpackage

/* rtl/bresenham_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// integer bresenham line generator for all octants, one pixel per item
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item is either a start (tuser = 0) carrying two endpoints
//   or a step (tuser = 1) whose tdata is ignored. a start sets up the line and
//   returns the first endpoint; each step returns the next pixel. a step while
//   no line is active is consumed and returns nothing. a start during a line
//   drops it and begins the new one.
//   m_* channel: one item per pixel, tlast marks the line's second endpoint.
// stages and throughput
//   an item is registered at the input, worked on while it sits in the input
//   stage, and its pixel is then registered in the output register. one item
//   per cycle is sustained while the receiver takes each pixel, the step
//   recurrence being one add and a sign test inside the input-stage cycle.
// reset and stalls
//   arst_n clears both stages and the line state (idle). when the receiver
//   stalls, the output register holds its pixel and the input stage keeps one
//   more item, then s_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
	localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input item channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y, zero fill
	input  logic                  s_tuser,  // mode
	// pixel channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // pixel_x, pixel_y, zero fill
	output logic                  m_tlast   // last_pixel
);

	localparam int CW = COORD_BITS;
	localparam int EW = COORD_BITS + 3;   // signed error term width

	// input stage
	logic                 valid_s1;
	logic                 mode_s1;
	logic [4*CW-1:0]      coords_s1;

	// line state
	logic [CW-1:0]        cur_x_q;
	logic [CW-1:0]        cur_y_q;
	logic signed [EW-1:0] error_q;
	logic signed [EW-1:0] diag_inc_q;
	logic signed [EW-1:0] straight_inc_q;
	logic                 x_neg_q;
	logic                 y_neg_q;
	logic                 x_major_q;
	logic [CW-1:0]        steps_left_q;
	logic                 line_active_q;

	// output register
	logic                 out_valid_q;
	logic [CW-1:0]        out_x_q;
	logic [CW-1:0]        out_y_q;
	logic                 out_last_q;

	// handshake
	logic advance;
	logic fire;
	logic is_start;
	logic emit;

	assign advance  = !out_valid_q || m_tready;   // output slot free this cycle
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign is_start = (mode_s1 == blr_pkg::MODE_START);
	assign emit     = fire && (is_start || line_active_q);

	// setup of a new line
	logic [CW-1:0]        sx, sy, ex, ey;
	logic                 set_x_neg, set_y_neg, set_x_major;
	logic [CW-1:0]        dx, dy, major, minor;
	logic signed [EW-1:0] two_minor, major_e, set_error, set_diag;

	assign sx = coords_s1[CW-1:0];
	assign sy = coords_s1[2*CW-1:CW];
	assign ex = coords_s1[3*CW-1:2*CW];
	assign ey = coords_s1[4*CW-1:3*CW];

	always_comb begin
		set_x_neg   = ex < sx;
		set_y_neg   = ey < sy;
		dx          = set_x_neg ? (sx - ex) : (ex - sx);
		dy          = set_y_neg ? (sy - ey) : (ey - sy);
		set_x_major = dx > dy;   // a tie goes y-major
		major       = set_x_major ? dx : dy;
		minor       = set_x_major ? dy : dx;
		two_minor   = $signed({2'b00, minor, 1'b0});
		major_e     = $signed({3'b000, major});
		set_error   = two_minor - major_e;
		set_diag    = two_minor - (major_e <<< 1);
	end

	// one step along the line
	logic [CW-1:0]        x_stepped, y_stepped;
	logic                 err_nonneg;
	logic [CW-1:0]        nxt_x, nxt_y;
	logic signed [EW-1:0] nxt_error;
	logic [CW-1:0]        nxt_steps;

	always_comb begin
		x_stepped  = x_neg_q ? (cur_x_q - CW'(1)) : (cur_x_q + CW'(1));
		y_stepped  = y_neg_q ? (cur_y_q - CW'(1)) : (cur_y_q + CW'(1));
		err_nonneg = !error_q[EW-1];
		// major axis always moves, minor axis only on a non-negative error
		nxt_x      = (x_major_q || err_nonneg) ? x_stepped : cur_x_q;
		nxt_y      = (!x_major_q || err_nonneg) ? y_stepped : cur_y_q;
		nxt_error  = error_q + (err_nonneg ? diag_inc_q : straight_inc_q);
		nxt_steps  = steps_left_q - CW'(1);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1   <= s_tuser;
			coords_s1 <= s_tdata[4*CW-1:0];
		end
	end

	// line state update, one item per fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			error_q        <= '0;
			diag_inc_q     <= '0;
			straight_inc_q <= '0;
			x_neg_q        <= 1'b0;
			y_neg_q        <= 1'b0;
			x_major_q      <= 1'b0;
			steps_left_q   <= '0;
			line_active_q  <= 1'b0;
		end else if (fire) begin
			if (is_start) begin
				cur_x_q        <= sx;
				cur_y_q        <= sy;
				error_q        <= set_error;
				diag_inc_q     <= set_diag;
				straight_inc_q <= two_minor;
				x_neg_q        <= set_x_neg;
				y_neg_q        <= set_y_neg;
				x_major_q      <= set_x_major;
				steps_left_q   <= major;
				line_active_q  <= (major != '0);
			end else if (line_active_q) begin
				cur_x_q       <= nxt_x;
				cur_y_q       <= nxt_y;
				error_q       <= nxt_error;
				steps_left_q  <= nxt_steps;
				line_active_q <= (nxt_steps != '0);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_start) begin
				out_x_q    <= sx;
				out_y_q    <= sy;
				out_last_q <= (major == '0);   // equal endpoints: single pixel
			end else begin
				out_x_q    <= nxt_x;
				out_y_q    <= nxt_y;
				out_last_q <= (nxt_steps == '0);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_y_q, out_x_q});
	assign m_tlast  = out_last_q;

endmodule

/* rtl/blr_checker.sv */
// ----------------------------------------------------------------------------
// blr_checker
// port-level checks for the bresenham line rasterizer
// ----------------------------------------------------------------------------
module blr_checker #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
	localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	logic in_accept;
	assign in_accept = s_tvalid && s_tready && (s_tuser || !s_tuser) && (s_tdata == s_tdata);

	// a stalled pixel stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("pixel dropped while stalled");

	// a stalled pixel keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel changed while stalled");

	// an empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// a fresh pixel comes from an item that passed the input and output registers
	a_pixel_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_accept, 2))
		else $error("pixel without an accepted item");

endmodule

bind bresenham_line_rasterizer_unit blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* tb/line_pixel_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_checker
// watches both item channels of the line rasterizer, traces every line on its
// own copy of the line state and compares each pixel with the oldest expected
// ----------------------------------------------------------------------------
module line_pixel_checker #(
	parameter int CW = blr_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((4 * CW + 7) / 8) * 8,
	localparam int OUT_W = ((2 * CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
	input  logic             s_tuser,   // mode
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y
	input  logic             m_tlast,   // last_pixel
	output int               mismatch_count,
	output int               pixels_outstanding
);

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          last;
	} pixel_t;

	pixel_t pending_pixels[$];
	pixel_t want_px;

	// traced line state
	logic [CW-1:0]        pos_x, pos_y, steps_left;
	logic signed [CW+2:0] err, diag_inc, straight_inc;
	logic                 x_neg, y_neg, x_major, line_on;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// advance the traced line by one item and queue the pixel it yields
	task automatic trace_line(input logic mode, input logic [IN_W-1:0] data);
		logic [CW-1:0] x1, y1, x2, y2, dx, dy;
		int            major, minor;
		if (mode == blr_pkg::MODE_START) begin
			x1 = data[CW-1:0];
			y1 = data[2*CW-1:CW];
			x2 = data[3*CW-1:2*CW];
			y2 = data[4*CW-1:3*CW];
			x_neg = x2 < x1;
			y_neg = y2 < y1;
			dx = x_neg ? x1 - x2 : x2 - x1;
			dy = y_neg ? y1 - y2 : y2 - y1;
			// a tie goes to y
			x_major = dx > dy;
			major = x_major ? int'(dx) : int'(dy);
			minor = x_major ? int'(dy) : int'(dx);
			err          = (CW+3)'(2 * minor - major);
			diag_inc     = (CW+3)'(2 * (minor - major));
			straight_inc = (CW+3)'(2 * minor);
			pos_x = x1;
			pos_y = y1;
			steps_left = CW'(major);
			line_on = steps_left != 0;
			pending_pixels.push_back({pos_x, pos_y, steps_left == 0});
		end else if (line_on) begin
			if (err >= 0) begin
				if (x_major)
					pos_y = y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
				else
					pos_x = x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
				err = err + diag_inc;
			end else begin
				err = err + straight_inc;
			end
			if (x_major)
				pos_x = x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
			else
				pos_y = y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
			steps_left = steps_left - 1'b1;
			line_on = steps_left != 0;
			pending_pixels.push_back({pos_x, pos_y, steps_left == 0});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x        = '0;
			pos_y        = '0;
			steps_left   = '0;
			err          = '0;
			diag_inc     = '0;
			straight_inc = '0;
			x_neg        = 1'b0;
			y_neg        = 1'b0;
			x_major      = 1'b0;
			line_on      = 1'b0;
			pending_pixels.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch("unexpected pixel, pixel_x", m_tdata[CW-1:0], -1);
				end else begin
					want_px = pending_pixels.pop_front();
					if (m_tdata[CW-1:0] !== want_px.x)
						report_mismatch("pixel_x", m_tdata[CW-1:0], want_px.x);
					if (m_tdata[2*CW-1:CW] !== want_px.y)
						report_mismatch("pixel_y", m_tdata[2*CW-1:CW], want_px.y);
					if (m_tlast !== want_px.last)
						report_mismatch("last_pixel", m_tlast, want_px.last);
				end
			end
			if (s_tvalid && s_tready)
				trace_line(s_tuser, s_tdata);
		end
		pixels_outstanding = pending_pixels.size();
	end

endmodule

/* tb/bresenham_line_rasterizer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit_tb
// drives start and step items into the line rasterizer with random idling on
// both channels and a line checker beside the block that predicts each pixel
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit_tb;

	localparam int CW    = blr_pkg::COORD_BITS_DEF;
	localparam int IN_W  = ((4 * CW + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CW + 7) / 8) * 8;

	// random part size, and where idling stops for the final stretch
	localparam int LINE_ITEMS = 700;
	localparam int CALM_ITEMS = 600;
	// points in the random part where the two pressure events happen
	localparam int HOLD_AT    = 250;
	localparam int PAUSE_AT   = 450;
	// receiver hold-off long enough to fill both block stages
	localparam int HOLDOFF_CYCLES = 150;
	// covers the block latency after the last pixel, padded
	localparam int DRAIN_CYCLES   = 10;
	// longest quiet stretch is the hold-off; stall bursts are shorter
	localparam int QUIET_LIMIT    = 1000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // start_x, start_y, end_x, end_y
	logic             s_tuser;   // mode
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // pixel_x, pixel_y
	logic             m_tlast;   // last_pixel

	int mismatch_count;
	int pixels_outstanding;
	int quiet_cycles = 0;

	// idling switches and the hold-off request shared by the two sides
	bit tx_idle      = 1'b1;
	bit rx_idle      = 1'b1;
	bit hold_request = 1'b0;

	always #1 clk = ~clk;

	bresenham_line_rasterizer_unit #(
		.COORD_BITS(CW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	line_pixel_checker #(
		.CW(CW)
	) pixel_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.s_tuser            (s_tuser),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tlast            (m_tlast),
		.mismatch_count     (mismatch_count),
		.pixels_outstanding (pixels_outstanding)
	);

	// watchdog: ends the run when no item moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[bresenham_line_rasterizer_unit] ERROR");
				$finish;
			end
		end
	end

	// receiver side: random stall bursts, plus one long hold-off on request
	initial begin
		int burst;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 4);
				m_tready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one item, entered and left at a falling edge
	task automatic send_item(input logic mode, input logic [IN_W-1:0] data);
		int gap;
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			s_tdata  <= IN_W'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// endpoints pack with start_x in the lowest bits
	task automatic start_line(input logic [CW-1:0] x1, y1, x2, y2);
		send_item(blr_pkg::MODE_START, {y2, x2, y1, x1});
	endtask

	// step items carry junk data, which the block must ignore
	task automatic step_line(input int count);
		repeat (count) send_item(blr_pkg::MODE_STEP, IN_W'({$urandom, $urandom}));
	endtask

	// stop offering and wait until every expected pixel has come out
	task automatic drain_pixels();
		s_tvalid <= 1'b0;
		wait (pixels_outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// coordinate with the edges of the range favored
	function automatic logic [CW-1:0] pick_coord();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return CW'($urandom_range(0, (1 << CW) - 1));
	endfunction

	// coordinate within span of base, kept inside the range
	function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] base, input int span);
		int off;
		off = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, span);
		if ($urandom_range(0, 1))
			return (int'(base) >= off) ? CW'(int'(base) - off) : CW'(int'(base) + off);
		return (int'(base) + off <= (1 << CW) - 1) ? CW'(int'(base) + off)
			: CW'(int'(base) - off);
	endfunction

	initial begin
		logic [CW-1:0] x1, y1, x2, y2;
		int line_items;
		int kind, span, dx, dy, major, n;
		bit hold_done;
		bit pause_done;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = blr_pkg::MODE_STEP;
		s_tdata  = '0;
		line_items = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed part
		// step with no line in progress, nothing comes out
		step_line(1);
		// equal endpoints at the top corner: one pixel, flagged last, then idle
		start_line('1, '1, '1, '1);
		step_line(1);
		// full-range diagonal, a tie so y leads, dropped after two steps
		start_line('0, '1, '1, '0);
		step_line(2);
		// restart mid-line: shallow line walking down in both axes, x leads
		start_line('1, '1, 12'd4090, 12'd4093);
		step_line(5);
		// steep line, x rising and y falling
		start_line(12'd2, 12'd7, 12'd5, 12'd1);
		step_line(6);
		// exact diagonal from a small origin
		start_line(12'd10, 12'd10, 12'd13, 12'd13);
		step_line(3);
		// one step past the end is ignored
		step_line(1);

		// random part: mostly complete lines with random endpoints, some cut
		// short, some wide lines that get abandoned, and stray steps
		while (line_items < LINE_ITEMS) begin
			if (line_items >= CALM_ITEMS) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end else begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end
			// long receiver hold-off while the sender keeps offering
			if (!hold_done && line_items >= HOLD_AT) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			// sender pause until the block has handed out everything
			if (!pause_done && line_items >= PAUSE_AT) begin
				drain_pixels();
				pause_done = 1'b1;
			end

			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				// stray steps, ignored unless a line is still running
				step_line($urandom_range(1, 3));
			end else begin
				x1 = pick_coord();
				y1 = pick_coord();
				if (kind == 8) begin
					x2 = pick_coord();
					y2 = pick_coord();
				end else begin
					span = ($urandom_range(0, 5) == 0) ? 60 : 12;
					x2 = near_coord(x1, span);
					y2 = near_coord(y1, span);
				end
				dx = (x2 > x1) ? int'(x2 - x1) : int'(x1 - x2);
				dy = (y2 > y1) ? int'(y2 - y1) : int'(y1 - y2);
				major = (dx > dy) ? dx : dy;
				if (kind == 8)
					n = (major < 20) ? major : $urandom_range(0, 20);
				else if (kind == 7)
					n = (major == 0) ? 0 : $urandom_range(0, major - 1);
				else
					n = major;
				start_line(x1, y1, x2, y2);
				step_line(n);
				line_items += n + 1;
				// sometimes run past the last pixel
				if (kind < 7 && $urandom_range(0, 3) == 0)
					step_line($urandom_range(1, 2));
			end
		end

		drain_pixels();
		if (mismatch_count == 0)
			$display("[bresenham_line_rasterizer_unit] OK");
		else
			$display("[bresenham_line_rasterizer_unit] ERROR");
		$finish;
	end

endmodule
